// ===== sv/inverse_depth_fusion_defines.svh =====
// ---------------------------------------------------------------------------
// Inverse depth fusion assertion macros
// Shared property wrappers for the checker; clocked on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef INVERSE_DEPTH_FUSION_DEFINES_SVH
`define INVERSE_DEPTH_FUSION_DEFINES_SVH

// The property holds at every clock edge outside reset.
`define IDF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define IDF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle property failed");

`endif

// ===== sv/idf_pkg.sv =====
// ---------------------------------------------------------------------------
// Inverse depth fusion package
// Shared types, widths and register indexes.
// ---------------------------------------------------------------------------
`default_nettype none
package idf_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int IN_W          = 128;
  localparam int OUT_W         = 152;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_W         = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_AGE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_UPPER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_LOWER   = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START,
    ST_WM1, ST_WM2, ST_WM3, ST_WLD, ST_WRES,
    ST_GM, ST_GLD, ST_GRES,
    ST_SQ, ST_SQLD, ST_QRES,
    ST_HM, ST_HLD, ST_HRES,
    ST_AM1, ST_AM2, ST_AM3, ST_ALD, ST_SCRES,
    ST_VM, ST_VLD, ST_VRES,
    ST_DIV, ST_FIN
  } st_t;

endpackage
`default_nettype wire

// ===== sv/inverse_depth_fusion.sv =====
// ---------------------------------------------------------------------------
// Inverse depth fusion
// Gaussian or Student-t fusion of inverse-depth measurements for one point.
// ---------------------------------------------------------------------------
// Usage: each input beat on the in_ stream carries one measurement; each
// measurement yields exactly one out_ beat with the fused state after it.
// The filter is picked by the filter_mode register, written through the
// cfg_ port; the user must write it only while the block is idle, which the block itself does not enforce.
// All arithmetic runs through one 32x32 multiplier and one restoring
// divider that produces one quotient bit per cycle, both driven by a
// small sequencer. The divider dominates the item time: a Gaussian
// update runs two divisions and a Student-t update up to five. A point
// that is still empty, or a zero weight sum, skips the arithmetic and
// goes straight to the final step.
// in_tready is high only while the sequencer is idle, so one item is in
// flight at a time. The result sits in an output register; if the receiver
// stalls, the next item may still be accepted and computed, and it waits in
// its final step until the output register frees up.
// Reset (rst_n low, synchronous) restores register defaults and empties
// the point: inverse depth -1.0, everything else zero.
// ---------------------------------------------------------------------------
`default_nettype none
module inverse_depth_fusion #(
  parameter int FRAC_BITS = idf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // in_tdata fields, lowest first: meas_inv_depth[31:0], meas_variance[63:32],
  // meas_scale_sq[95:64], meas_dof[127:96]
  input  wire logic [idf_pkg::IN_W-1:0]    in_tdata,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // out_tdata fields, lowest first: fused_inv_depth[31:0],
  // fused_variance[63:32], fused_scale_sq[95:64], fused_dof[127:96],
  // fusion_age[143:128], has_estimate[144], qualified[145], zero pad
  output logic [idf_pkg::OUT_W-1:0]        out_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  input  wire logic                        cfg_we,
  input  wire logic [idf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [idf_pkg::CFG_W-1:0]   cfg_wdata
);
  import idf_pkg::*;

  localparam int SH = FRAC_BITS - 16;
  localparam longint unsigned EPS_RAW =
    ((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam logic [31:0] EPS_Q = (EPS_RAW == 0) ? 32'd1 : 32'(EPS_RAW);
  localparam logic [32:0] NEG_EPS = 33'd0 - {1'b0, EPS_Q};
  localparam logic [31:0] INV_EMPTY = 32'd0 - (32'd1 << FRAC_BITS);
  localparam logic [31:0] SGN = 32'h8000_0000;
  localparam logic [31:0] DOF_TWO = 32'h0002_0000;

  // Configuration registers.
  logic        mode_r;
  logic [31:0] var_lim_r, upper_r, lower_r;
  logic [15:0] min_age_r;

  // Point state.
  logic [31:0] est_inv_r, est_var_r, est_sc_r, est_dof_r;
  logic [15:0] est_age_r;

  // Sequencer and working registers.
  st_t         state_r, state_nxt, ret_r, ret_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt, lo_r, lo_nxt, den_r, den_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [95:0] acc_r, acc_nxt;
  logic [31:0] m_r, vm_r, sm_r, nm_r;
  logic [31:0] nu_r, nu_nxt;
  logic [32:0] s_r, s_nxt;
  logic [63:0] a_r, a_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] inv_r, inv_nxt, var_r, var_nxt, sc_r, sc_nxt, dof_r, dof_nxt;
  logic [15:0] age_r, age_nxt;
  logic        commit;

  // Output register.
  logic [OUT_W-1:0] out_data_r;
  logic             out_valid_r;

  // Shared multiplier operands.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Divider load request.
  logic        ld;
  logic [63:0] ld_hi, ld_lo, ld_den;
  st_t         ld_ret;

  // Divider step.
  logic [63:0] dv_sh, dv_sub;
  logic        dv_take;
  always_comb begin
    dv_sh   = {rem_r[62:0], lo_r[63]};
    dv_take = rem_r[63] || (dv_sh >= den_r);
    dv_sub  = dv_sh - den_r;
  end

  // Helpers from the working state.
  logic [31:0] ue, um, ad, w_e, w_m;
  logic [32:0] dd, s_in, dof_sum;
  logic [64:0] a_sum;
  logic [63:0] b_den;
  logic        has_old, has_new, qual;
  always_comb begin
    ue     = est_inv_r ^ SGN;
    um     = m_r ^ SGN;
    dd     = {1'b0, ue} - {1'b0, um};
    ad     = dd[32] ? 32'(33'd0 - dd) : dd[31:0];
    w_e    = mode_r ? est_sc_r : est_var_r;
    w_m    = mode_r ? sm_r : vm_r;
    s_in   = {1'b0, w_e} + {1'b0, w_m};
    dof_sum = {1'b0, ((nm_r < est_dof_r) ? nm_r : est_dof_r)} + 33'h0_0001_0000;
    a_sum  = (65'(nu_r) << SH) + {1'b0, lo_r};
    b_den  = (64'(nu_r) << SH) + (64'd1 << FRAC_BITS);
    has_old = $signed({est_inv_r[31], est_inv_r}) > $signed(NEG_EPS);
    has_new = $signed({inv_r[31], inv_r}) > $signed(NEG_EPS);
    qual   = has_new && (age_r >= min_age_r) && (var_r <= var_lim_r) &&
             ($signed(inv_r) <= $signed(upper_r)) &&
             ($signed(inv_r) >= $signed(lower_r));
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    lo_nxt    = lo_r;
    den_nxt   = den_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    nu_nxt    = nu_r;
    s_nxt     = s_r;
    a_nxt     = a_r;
    h_nxt     = h_r;
    inv_nxt   = inv_r;
    var_nxt   = var_r;
    sc_nxt    = sc_r;
    dof_nxt   = dof_r;
    age_nxt   = age_r;
    mul_a     = '0;
    mul_b     = '0;
    ld        = 1'b0;
    ld_hi     = '0;
    ld_lo     = '0;
    ld_den    = '0;
    ld_ret    = ST_IDLE;
    commit    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        inv_nxt = est_inv_r;
        var_nxt = est_var_r;
        sc_nxt  = est_sc_r;
        dof_nxt = est_dof_r;
        age_nxt = est_age_r;
        s_nxt   = s_in;
        nu_nxt  = (nm_r < est_dof_r) ? nm_r : est_dof_r;
        state_nxt = ST_FIN;
        if (!has_old) begin
          // Empty point: the measurement is taken over as it is (Gaussian mode clamps the variance to at least EPS_Q).
          inv_nxt = m_r;
          if (mode_r) begin
            var_nxt = vm_r;
            sc_nxt  = sm_r;
            dof_nxt = nm_r;
          end else begin
            var_nxt = (vm_r < EPS_Q) ? EPS_Q : vm_r;
          end
        end else begin
          if (mode_r) begin
            dof_nxt = dof_sum[32] ? '1 : dof_sum[31:0];
            age_nxt = (est_age_r == 16'hFFFF) ? est_age_r : est_age_r + 16'd1;
          end
          if (s_in == 33'd0) begin
            var_nxt = '1;
            if (mode_r) begin
              sc_nxt = '0;
            end
          end else begin
            state_nxt = ST_WM1;
          end
        end
      end
      ST_WM1: begin
        mul_a = w_e;
        mul_b = um;
        prod_nxt = mul_p;
        state_nxt = ST_WM2;
      end
      ST_WM2: begin
        acc_nxt = 96'(prod_r);
        mul_a = w_m;
        mul_b = ue;
        prod_nxt = mul_p;
        state_nxt = ST_WM3;
      end
      ST_WM3: begin
        acc_nxt = acc_r + 96'(prod_r);
        state_nxt = ST_WLD;
      end
      ST_WLD: begin
        ld = 1'b1;
        ld_hi = 64'(acc_r[95:64]);
        ld_lo = acc_r[63:0];
        ld_den = 64'(s_r);
        ld_ret = ST_WRES;
      end
      ST_WRES: begin
        inv_nxt = lo_r[31:0] ^ SGN;
        state_nxt = mode_r ? ST_SQ : ST_GM;
      end
      ST_GM: begin
        mul_a = est_var_r;
        mul_b = vm_r;
        prod_nxt = mul_p;
        state_nxt = ST_GLD;
      end
      ST_GLD: begin
        ld = 1'b1;
        ld_lo = prod_r;
        ld_den = 64'(s_r);
        ld_ret = ST_GRES;
      end
      ST_GRES: begin
        var_nxt = (lo_r[31:0] < EPS_Q) ? EPS_Q : lo_r[31:0];
        state_nxt = ST_FIN;
      end
      ST_SQ: begin
        mul_a = ad;
        mul_b = ad;
        prod_nxt = mul_p;
        state_nxt = ST_SQLD;
      end
      ST_SQLD: begin
        ld = 1'b1;
        ld_lo = prod_r;
        ld_den = 64'(s_r);
        ld_ret = ST_QRES;
      end
      ST_QRES: begin
        a_nxt = a_sum[64] ? '1 : a_sum[63:0];
        state_nxt = ST_HM;
      end
      ST_HM: begin
        mul_a = est_sc_r;
        mul_b = sm_r;
        prod_nxt = mul_p;
        state_nxt = ST_HLD;
      end
      ST_HLD: begin
        ld = 1'b1;
        ld_lo = prod_r;
        ld_den = 64'(s_r);
        ld_ret = ST_HRES;
      end
      ST_HRES: begin
        h_nxt = lo_r[31:0];
        state_nxt = ST_AM1;
      end
      ST_AM1: begin
        mul_a = a_r[31:0];
        mul_b = h_r;
        prod_nxt = mul_p;
        state_nxt = ST_AM2;
      end
      ST_AM2: begin
        acc_nxt = 96'(prod_r);
        mul_a = a_r[63:32];
        mul_b = h_r;
        prod_nxt = mul_p;
        state_nxt = ST_AM3;
      end
      ST_AM3: begin
        acc_nxt = acc_r + {prod_r, 32'd0};
        state_nxt = ST_ALD;
      end
      ST_ALD: begin
        ld = 1'b1;
        ld_hi = 64'(acc_r[95:64]);
        ld_lo = acc_r[63:0];
        ld_den = b_den;
        ld_ret = ST_SCRES;
      end
      ST_SCRES: begin
        sc_nxt = (lo_r[63:32] != 32'd0) ? '1 : lo_r[31:0];
        if (dof_r <= DOF_TWO) begin
          var_nxt = '1;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_VM;
        end
      end
      ST_VM: begin
        mul_a = dof_r;
        mul_b = sc_r;
        prod_nxt = mul_p;
        state_nxt = ST_VLD;
      end
      ST_VLD: begin
        ld = 1'b1;
        ld_lo = prod_r;
        ld_den = 64'(dof_r - DOF_TWO);
        ld_ret = ST_VRES;
      end
      ST_VRES: begin
        var_nxt = (lo_r[63:32] != 32'd0) ? '1 : lo_r[31:0];
        state_nxt = ST_FIN;
      end
      ST_DIV: begin
        rem_nxt = dv_take ? dv_sub : dv_sh;
        lo_nxt  = {lo_r[62:0], dv_take};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          state_nxt = ret_r;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          commit = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (ld) begin
      den_nxt = ld_den;
      if (ld_hi >= ld_den) begin
        // Quotient would not fit: saturate.
        lo_nxt = '1;
        state_nxt = ld_ret;
      end else begin
        rem_nxt = ld_hi;
        lo_nxt  = ld_lo;
        cnt_nxt = 6'd63;
        ret_nxt = ld_ret;
        state_nxt = ST_DIV;
      end
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
      var_lim_r   <= 32'd16777216;
      min_age_r   <= 16'd0;
      upper_r     <= 32'd167772160;
      lower_r     <= 32'd0;
      est_inv_r   <= INV_EMPTY;
      est_var_r   <= '0;
      est_sc_r    <= '0;
      est_dof_r   <= '0;
      est_age_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_FILTER_MODE: mode_r    <= cfg_wdata[0];
          REG_VAR_LIMIT:   var_lim_r <= cfg_wdata;
          REG_MIN_AGE:     min_age_r <= cfg_wdata[15:0];
          REG_INV_UPPER:   upper_r   <= cfg_wdata;
          REG_INV_LOWER:   lower_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (commit) begin
        out_valid_r <= 1'b1;
        est_inv_r   <= inv_r;
        est_var_r   <= var_r;
        est_sc_r    <= sc_r;
        est_dof_r   <= dof_r;
        est_age_r   <= age_r;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      m_r  <= in_tdata[31:0];
      vm_r <= in_tdata[63:32];
      sm_r <= in_tdata[95:64];
      nm_r <= in_tdata[127:96];
    end
    if (commit) begin
      out_data_r <= {6'd0, qual, has_new, age_r, dof_r, sc_r, var_r, inv_r};
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    lo_r   <= lo_nxt;
    den_r  <= den_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    nu_r   <= nu_nxt;
    s_r    <= s_nxt;
    a_r    <= a_nxt;
    h_r    <= h_nxt;
    inv_r  <= inv_nxt;
    var_r  <= var_nxt;
    sc_r   <= sc_nxt;
    dof_r  <= dof_nxt;
    age_r  <= age_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/idf_checker.sv =====
// ---------------------------------------------------------------------------
// Inverse depth fusion checker
// Port-level properties, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "inverse_depth_fusion_defines.svh"
module idf_checker (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_tvalid,
  input wire logic                     in_tready,
  input wire logic                     out_tvalid,
  input wire logic                     out_tready,
  input wire logic [idf_pkg::OUT_W-1:0] out_tdata
);
  import idf_pkg::*;

  // One item at a time: after an input beat the block is busy.
  `IDF_ASSERT_NEXT(a_busy_after_in, in_tvalid && in_tready, !in_tready)
  // A qualified estimate is always a real estimate.
  `IDF_ASSERT(a_qual_has, !out_tvalid || !out_tdata[145] || out_tdata[144])
  // A stalled result beat stays offered and unchanged.
  `IDF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `IDF_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata))

endmodule

bind inverse_depth_fusion idf_checker u_idf_checker (.*);
`default_nettype wire
